FILE: sv/ntwa_pkg.sv
// Package: types, constants and codes shared by the neighbour table modules.
`default_nettype none
package ntwa_pkg;
	localparam int CAPACITY = 16;
	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int MAXOUT = 16;
	localparam int QDEPTH = 2;

	typedef enum logic [2:0] {
		K_HELLO  = 3'd0,
		K_PURGE  = 3'd1,
		K_LOOKUP = 3'd2,
		K_REMOVE = 3'd3,
		K_CLEAR  = 3'd4,
		K_LIST   = 3'd5
	} kind_e;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_SELF     = 3'd1;
	localparam logic [2:0] ST_MISMATCH = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	localparam logic REG_OWN_ID  = 1'b0;
	localparam logic REG_TIMEOUT = 1'b1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] sender_id;
		logic [31:0] sender_lane;
		logic [31:0] sender_road;
		logic signed [31:0] sender_pos_x;
		logic signed [31:0] sender_pos_y;
		logic signed [31:0] sender_speed;
		logic [7:0]  sender_direction;
		logic [31:0] my_lane;
		logic [7:0]  my_direction;
		logic [31:0] now_time;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        found;
		logic [8:0]  removed_count;
		logic [31:0] entry_id;
		logic [31:0] entry_lane;
		logic [31:0] entry_road;
		logic signed [31:0] entry_pos_x;
		logic signed [31:0] entry_pos_y;
		logic signed [31:0] entry_speed;
		logic [7:0]  entry_direction;
		logic [31:0] entry_seen;
		logic        last;
	} result_t;

	// Classified command passed from front to back.
	typedef enum logic [2:0] {
		OP_REPLY,
		OP_HELLO,
		OP_PURGE,
		OP_LOOKUP,
		OP_REMOVE,
		OP_CLEAR,
		OP_LIST
	} op_e;

	typedef struct packed {
		op_e        op;
		logic [2:0] status;
		cmd_t       cmd;
	} job_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] lane;
		logic [31:0] road;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] speed;
		logic [7:0]  direction;
		logic [31:0] seen;
	} entry_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SCAN,
		B_ACT,
		B_READ,
		B_EMIT,
		B_LSCAN,
		B_LEMIT
	} bstate_e;
endpackage
`default_nettype wire

FILE: sv/neighbor_table_with_aging.sv
// Top level: neighbour table with aging, front/back split with job queue.
// Channel  | Handshake          | Payload
// command  | start / busy       | cmd (cmd_t)
// result   | res_valid strobe   | result (result_t), one cycle, no stall
// config   | cfg_valid/cfg_ready| cfg_index, cfg_data
// Hello, remove, purge and lookup sweep every slot before acting; a lookup hit also reads its slot.
// List: one sweep per reported entry plus one closing sweep, unless it reports
// MAXOUT entries; other commands take no sweep.
// Reset clears valid bits, queue and control; slot payload is not cleared.
// busy rises when the two-entry job queue is full.
`default_nettype none
module neighbor_table_with_aging (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire ntwa_pkg::cmd_t    cmd,
	output logic                   busy,
	output logic                   res_valid,
	output ntwa_pkg::result_t      result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [31:0]       cfg_data
);
	logic [31:0]    own_id_q, timeout_q;
	logic           job_valid, job_pop, idle;
	ntwa_pkg::job_t job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
			timeout_q <= 32'd3000;
		end else if (cfg_valid) begin
			if (cfg_index == ntwa_pkg::REG_OWN_ID) own_id_q <= cfg_data;
			else timeout_q <= cfg_data;
		end
	end

	ntwa_front u_front (
		.clk, .arst_n, .start, .cmd, .own_id(own_id_q), .busy,
		.job_valid, .job, .job_pop
	);

	ntwa_back u_back (
		.clk, .arst_n, .job_valid, .job, .job_pop, .stale_timeout(timeout_q),
		.res_valid, .result, .idle
	);

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(idle && !job_valid) |=> !res_valid || $past(!idle)) else $error("spurious result");
endmodule
`default_nettype wire

FILE: sv/ntwa_front.sv
// Front end: command accept, hello pre-checks and job queue.
`default_nettype none
module ntwa_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire ntwa_pkg::cmd_t cmd,
	input  wire logic [31:0]    own_id,
	output logic                busy,
	output logic                job_valid,
	output ntwa_pkg::job_t      job,
	input  wire logic           job_pop
);
	ntwa_pkg::job_t q_mem_q [ntwa_pkg::QDEPTH];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	ntwa_pkg::job_t nj;
	logic           push;

	assign busy = (cnt_q == 2'(ntwa_pkg::QDEPTH));
	assign push = start && !busy;
	assign job_valid = (cnt_q != 2'd0);
	assign job = q_mem_q[rp_q];

	always_comb begin
		nj.cmd = cmd;
		nj.status = ntwa_pkg::ST_OK;
		unique case (cmd.kind)
			ntwa_pkg::K_HELLO: begin
				if (cmd.sender_id == own_id) begin
					nj.op = ntwa_pkg::OP_REPLY;
					nj.status = ntwa_pkg::ST_SELF;
				end else if (cmd.sender_lane != cmd.my_lane ||
					cmd.sender_direction != cmd.my_direction) begin
					nj.op = ntwa_pkg::OP_REPLY;
					nj.status = ntwa_pkg::ST_MISMATCH;
				end else begin
					nj.op = ntwa_pkg::OP_HELLO;
				end
			end
			ntwa_pkg::K_PURGE:  nj.op = ntwa_pkg::OP_PURGE;
			ntwa_pkg::K_LOOKUP: nj.op = ntwa_pkg::OP_LOOKUP;
			ntwa_pkg::K_REMOVE: nj.op = ntwa_pkg::OP_REMOVE;
			ntwa_pkg::K_CLEAR:  nj.op = ntwa_pkg::OP_CLEAR;
			ntwa_pkg::K_LIST:   nj.op = ntwa_pkg::OP_LIST;
			default:            nj.op = ntwa_pkg::OP_REPLY;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wp_q] <= nj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (job_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(job_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'(ntwa_pkg::QDEPTH)) else $error("queue overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid) else $error("pop of empty queue");
	a_full_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'(ntwa_pkg::QDEPTH)) |-> busy) else $error("busy missing");
endmodule
`default_nettype wire

FILE: sv/ntwa_back.sv
// Back end: slot table, sweeps over slots and result generation.
`default_nettype none
module ntwa_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	input  wire ntwa_pkg::job_t job,
	output logic                job_pop,
	input  wire logic [31:0]    stale_timeout,
	output logic                res_valid,
	output ntwa_pkg::result_t   result,
	output logic                idle
);
	localparam int SW = ntwa_pkg::SLOT_W;

	ntwa_pkg::entry_t    mem [ntwa_pkg::CAPACITY];
	logic [ntwa_pkg::CAPACITY-1:0] valid_q;
	ntwa_pkg::bstate_e   st_q, st_d;
	ntwa_pkg::job_t      job_q;
	logic [SW:0]         idx_q;
	logic                hit_q, free_q;
	logic [SW-1:0]       hit_slot_q, free_slot_q, best_q;
	logic                have_best_q, have_prev_q;
	logic [31:0]         best_id_q, prev_id_q;
	logic [8:0]          rm_q;
	logic [4:0]          nout_q;
	ntwa_pkg::entry_t    rd_q;
	logic [SW-1:0]       rd_addr;
	logic                rd_en;
	ntwa_pkg::entry_t    wr_e;
	logic                wr_en;
	logic [SW-1:0]       wr_addr;
	logic [SW-1:0]       cur;
	logic                lpick;
	ntwa_pkg::result_t   res_d;
	logic                res_v_d;
	ntwa_pkg::result_t   out_r;
	logic                out_v;
	// The emitted list result is the last only if no further entry exists; check by
	// one-ahead scan: a found entry is held, the next scan decides the end.
	logic                pend_q;
	ntwa_pkg::result_t   pend_r_q;

	assign cur = idx_q[SW-1:0];
	assign lpick = (idx_q != '0) && valid_q[cur - SW'(1)] &&
		(!have_prev_q || rd_q.id > prev_id_q) &&
		(!have_best_q || rd_q.id < best_id_q);

	// Sweep reads one slot per cycle; read data registered.
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_e;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_comb begin
		wr_e.id = job_q.cmd.sender_id;
		wr_e.lane = job_q.cmd.sender_lane;
		wr_e.road = job_q.cmd.sender_road;
		wr_e.pos_x = job_q.cmd.sender_pos_x;
		wr_e.pos_y = job_q.cmd.sender_pos_y;
		wr_e.speed = job_q.cmd.sender_speed;
		wr_e.direction = job_q.cmd.sender_direction;
		wr_e.seen = job_q.cmd.now_time;
		wr_addr = hit_q ? hit_slot_q : free_slot_q;
		wr_en = (st_q == ntwa_pkg::B_ACT) && (job_q.op == ntwa_pkg::OP_HELLO) &&
			(hit_q || free_q);
	end

	always_comb begin
		st_d = st_q;
		job_pop = 1'b0;
		rd_en = 1'b0;
		rd_addr = cur;
		res_v_d = 1'b0;
		res_d = '0;
		res_d.last = 1'b1;
		unique case (st_q)
			ntwa_pkg::B_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					st_d = (job.op == ntwa_pkg::OP_REPLY) ? ntwa_pkg::B_EMIT :
						(job.op == ntwa_pkg::OP_CLEAR) ? ntwa_pkg::B_ACT :
						(job.op == ntwa_pkg::OP_LIST) ? ntwa_pkg::B_LSCAN :
						ntwa_pkg::B_SCAN;
				end
			end
			ntwa_pkg::B_SCAN: begin
				rd_en = 1'b1;
				if (idx_q == (SW+1)'(ntwa_pkg::CAPACITY)) st_d = ntwa_pkg::B_ACT;
			end
			ntwa_pkg::B_ACT: begin
				if (job_q.op == ntwa_pkg::OP_LOOKUP && hit_q) begin
					rd_en = 1'b1;
					rd_addr = hit_slot_q;
					st_d = ntwa_pkg::B_READ;
				end else begin
					st_d = ntwa_pkg::B_EMIT;
				end
			end
			ntwa_pkg::B_READ: st_d = ntwa_pkg::B_EMIT;
			ntwa_pkg::B_EMIT: begin
				res_v_d = 1'b1;
				unique case (job_q.op)
					ntwa_pkg::OP_REPLY: res_d.status = job_q.status;
					ntwa_pkg::OP_HELLO:
						res_d.status = (hit_q || free_q) ? ntwa_pkg::ST_OK :
							ntwa_pkg::ST_FULL;
					ntwa_pkg::OP_PURGE: res_d.removed_count = rm_q;
					ntwa_pkg::OP_LOOKUP, ntwa_pkg::OP_REMOVE: begin
						res_d.status = hit_q ? ntwa_pkg::ST_OK : ntwa_pkg::ST_NOTFOUND;
						if (job_q.op == ntwa_pkg::OP_LOOKUP && hit_q) begin
							res_d.found = 1'b1;
							res_d.entry_id = rd_q.id;
							res_d.entry_lane = rd_q.lane;
							res_d.entry_road = rd_q.road;
							res_d.entry_pos_x = rd_q.pos_x;
							res_d.entry_pos_y = rd_q.pos_y;
							res_d.entry_speed = rd_q.speed;
							res_d.entry_direction = rd_q.direction;
							res_d.entry_seen = rd_q.seen;
						end
					end
					default: ;
				endcase
				st_d = ntwa_pkg::B_IDLE;
			end
			ntwa_pkg::B_LSCAN: begin
				rd_en = 1'b1;
				if (idx_q == (SW+1)'(ntwa_pkg::CAPACITY)) begin
					// last slot may become the best at this very edge
					rd_addr = lpick ? (cur - SW'(1)) : best_q;
					st_d = ntwa_pkg::B_LEMIT;
				end
			end
			ntwa_pkg::B_LEMIT: begin
				res_d.found = have_best_q;
				res_d.last = !have_best_q || (nout_q == 5'(ntwa_pkg::MAXOUT - 1));
				if (have_best_q) begin
					res_d.entry_id = rd_q.id;
					res_d.entry_lane = rd_q.lane;
					res_d.entry_road = rd_q.road;
					res_d.entry_pos_x = rd_q.pos_x;
					res_d.entry_pos_y = rd_q.pos_y;
					res_d.entry_speed = rd_q.speed;
					res_d.entry_direction = rd_q.direction;
					res_d.entry_seen = rd_q.seen;
				end
				res_v_d = have_best_q || nout_q == 5'd0;
				st_d = res_d.last ? ntwa_pkg::B_IDLE : ntwa_pkg::B_LSCAN;
			end
			default: st_d = ntwa_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		out_v = 1'b0;
		out_r = res_d;
		if (st_q == ntwa_pkg::B_LEMIT) begin
			if (pend_q) begin
				out_v = 1'b1;
				out_r = pend_r_q;
				out_r.last = !have_best_q;
			end else if (res_d.last && (have_best_q || nout_q == 5'd0)) begin
				out_v = 1'b1;
			end
		end else if (st_q == ntwa_pkg::B_IDLE && pend_q) begin
			out_v = 1'b1;
			out_r = pend_r_q;
		end else if (st_q == ntwa_pkg::B_EMIT) begin
			out_v = res_v_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ntwa_pkg::B_IDLE;
			valid_q <= '0;
			idx_q <= '0;
			res_valid <= 1'b0;
			result <= '0;
			pend_q <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			have_best_q <= 1'b0;
			have_prev_q <= 1'b0;
			nout_q <= '0;
			rm_q <= '0;
		end else begin
			st_q <= st_d;
			res_valid <= out_v;
			result <= out_r;
			if (st_q == ntwa_pkg::B_IDLE && job_valid) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
				rm_q <= '0;
				have_best_q <= 1'b0;
				have_prev_q <= 1'b0;
				nout_q <= '0;
			end
			if (st_q == ntwa_pkg::B_SCAN) begin
				if (idx_q != '0) begin
					if (valid_q[cur - SW'(1)]) begin
						if (rd_q.id == job_q.cmd.sender_id && !hit_q) begin
							hit_q <= 1'b1;
							hit_slot_q <= cur - SW'(1);
						end
						if (job_q.op == ntwa_pkg::OP_PURGE &&
							(job_q.cmd.now_time - rd_q.seen) > stale_timeout) begin
							valid_q[cur - SW'(1)] <= 1'b0;
							rm_q <= rm_q + 9'd1;
						end
					end else if (!free_q) begin
						free_q <= 1'b1;
						free_slot_q <= cur - SW'(1);
					end
				end
				idx_q <= (idx_q == (SW+1)'(ntwa_pkg::CAPACITY)) ? '0 : idx_q + 1'b1;
			end
			if (st_q == ntwa_pkg::B_ACT) begin
				unique case (job_q.op)
					ntwa_pkg::OP_HELLO: if (hit_q || free_q)
						valid_q[wr_addr] <= 1'b1;
					ntwa_pkg::OP_REMOVE: if (hit_q) valid_q[hit_slot_q] <= 1'b0;
					ntwa_pkg::OP_CLEAR: valid_q <= '0;
					default: ;
				endcase
			end
			if (st_q == ntwa_pkg::B_LSCAN) begin
				if (lpick) begin
					have_best_q <= 1'b1;
					best_q <= cur - SW'(1);
					best_id_q <= rd_q.id;
				end
				idx_q <= (idx_q == (SW+1)'(ntwa_pkg::CAPACITY)) ? '0 : idx_q + 1'b1;
			end
			if (st_q == ntwa_pkg::B_LEMIT) begin
				// hold found entry; released with correct last after next scan
				if (have_best_q) begin
					pend_r_q <= res_d;
					have_prev_q <= 1'b1;
					prev_id_q <= best_id_q;
					nout_q <= nout_q + 5'd1;
				end
				pend_q <= have_best_q && (pend_q || !res_d.last);
				have_best_q <= 1'b0;
			end else if (st_q == ntwa_pkg::B_IDLE && pend_q) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ntwa_pkg::B_IDLE && job_valid) job_q <= job;
	end

	assign idle = (st_q == ntwa_pkg::B_IDLE) && !pend_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> st_q == ntwa_pkg::B_IDLE) else $error("pop while working");
	a_res_state: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> $past(st_q) != ntwa_pkg::B_SCAN) else $error("result during scan");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= (SW+1)'(ntwa_pkg::CAPACITY)) else $error("index out of range");
endmodule
`default_nettype wire

FILE: tb/neighbor_table_with_aging_tb.sv
// Testbench for the neighbour table with aging: random commands checked against a predictor.
`default_nettype none
module neighbor_table_with_aging_tb;

	class table_scoreboard;
		ntwa_pkg::result_t expected_q[$];
		int unsigned errors;
		logic [31:0] own_id;
		logic [31:0] timeout;
		bit          v[ntwa_pkg::CAPACITY];
		ntwa_pkg::entry_t e[ntwa_pkg::CAPACITY];

		function void reset_state();
			own_id = 0;
			timeout = 3000;
			errors = 0;
			foreach (v[i]) v[i] = 0;
		endfunction

		function void write_reg(logic idx, logic [31:0] d);
			if (idx == ntwa_pkg::REG_OWN_ID) own_id = d;
			else timeout = d;
		endfunction

		function void expect_result(ntwa_pkg::result_t r);
			expected_q = {expected_q, r};
		endfunction

		function ntwa_pkg::result_t blank(logic [2:0] st);
			ntwa_pkg::result_t r;
			r = '0;
			r.status = st;
			r.last = 1'b1;
			return r;
		endfunction

		function int find_id(logic [31:0] id);
			for (int i = 0; i < ntwa_pkg::CAPACITY; i++)
				if (v[i] && e[i].id == id) return i;
			return -1;
		endfunction

		function ntwa_pkg::result_t from_slot(int s);
			ntwa_pkg::result_t r;
			r = '0;
			r.found = 1'b1;
			r.entry_id = e[s].id;
			r.entry_lane = e[s].lane;
			r.entry_road = e[s].road;
			r.entry_pos_x = e[s].pos_x;
			r.entry_pos_y = e[s].pos_y;
			r.entry_speed = e[s].speed;
			r.entry_direction = e[s].direction;
			r.entry_seen = e[s].seen;
			return r;
		endfunction

		function void note_command(ntwa_pkg::cmd_t c);
			int s;
			int n;
			int best;
			bit have_prev;
			logic [31:0] prev;
			logic [8:0] cnt;
			ntwa_pkg::result_t r;
			ntwa_pkg::result_t picks[$];
			case (c.kind)
				ntwa_pkg::K_HELLO: begin
					if (c.sender_id == own_id) expect_result(blank(ntwa_pkg::ST_SELF));
					else if (c.sender_lane != c.my_lane || c.sender_direction != c.my_direction)
						expect_result(blank(ntwa_pkg::ST_MISMATCH));
					else begin
						s = find_id(c.sender_id);
						if (s < 0)
							for (int i = 0; i < ntwa_pkg::CAPACITY; i++)
								if (!v[i]) begin
									s = i;
									break;
								end
						if (s < 0) expect_result(blank(ntwa_pkg::ST_FULL));
						else begin
							v[s] = 1;
							e[s] = '{c.sender_id, c.sender_lane, c.sender_road, c.sender_pos_x,
								c.sender_pos_y, c.sender_speed, c.sender_direction, c.now_time};
							expect_result(blank(ntwa_pkg::ST_OK));
						end
					end
				end
				ntwa_pkg::K_PURGE: begin
					cnt = 0;
					for (int i = 0; i < ntwa_pkg::CAPACITY; i++)
						if (v[i] && (c.now_time - e[i].seen) > timeout) begin
							v[i] = 0;
							cnt++;
						end
					r = blank(ntwa_pkg::ST_OK);
					r.removed_count = cnt;
					expect_result(r);
				end
				ntwa_pkg::K_LOOKUP: begin
					s = find_id(c.sender_id);
					if (s < 0) expect_result(blank(ntwa_pkg::ST_NOTFOUND));
					else begin
						r = from_slot(s);
						r.last = 1'b1;
						expect_result(r);
					end
				end
				ntwa_pkg::K_REMOVE: begin
					s = find_id(c.sender_id);
					if (s >= 0) v[s] = 0;
					expect_result(blank(s < 0 ? ntwa_pkg::ST_NOTFOUND : ntwa_pkg::ST_OK));
				end
				ntwa_pkg::K_CLEAR: begin
					foreach (v[i]) v[i] = 0;
					expect_result(blank(ntwa_pkg::ST_OK));
				end
				ntwa_pkg::K_LIST: begin
					have_prev = 0;
					prev = 0;
					n = 0;
					while (n < ntwa_pkg::MAXOUT) begin
						best = -1;
						for (int i = 0; i < ntwa_pkg::CAPACITY; i++)
							if (v[i] && !(have_prev && e[i].id <= prev))
								if (best < 0 || e[i].id < e[best].id) best = i;
						if (best < 0) break;
						picks = {picks, from_slot(best)};
						prev = e[best].id;
						have_prev = 1;
						n++;
					end
					if (n == 0) expect_result(blank(ntwa_pkg::ST_OK));
					else begin
						picks[n-1].last = 1'b1;
						foreach (picks[i]) expect_result(picks[i]);
					end
				end
				default: expect_result(blank(ntwa_pkg::ST_OK));
			endcase
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $time, what);
			errors++;
		endtask

		task check_result(ntwa_pkg::result_t got);
			ntwa_pkg::result_t x;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result %h", got));
				return;
			end
			x = expected_q.pop_front();
			if (got.status !== x.status) report($sformatf("status %0d exp %0d", got.status, x.status));
			if (got.found !== x.found) report($sformatf("found %0d exp %0d", got.found, x.found));
			if (got.removed_count !== x.removed_count)
				report($sformatf("removed %0d exp %0d", got.removed_count, x.removed_count));
			if (got.entry_id !== x.entry_id) report($sformatf("id %h exp %h", got.entry_id, x.entry_id));
			if (got.entry_lane !== x.entry_lane) report("entry_lane");
			if (got.entry_road !== x.entry_road) report("entry_road");
			if (got.entry_pos_x !== x.entry_pos_x) report("entry_pos_x");
			if (got.entry_pos_y !== x.entry_pos_y) report("entry_pos_y");
			if (got.entry_speed !== x.entry_speed) report("entry_speed");
			if (got.entry_direction !== x.entry_direction) report("entry_direction");
			if (got.entry_seen !== x.entry_seen) report("entry_seen");
			if (got.last !== x.last) report($sformatf("last %0d exp %0d", got.last, x.last));
		endtask
	endclass

	localparam int CYCLE_LIMIT = 400000;

	logic clk;
	logic arst_n;
	logic start;
	ntwa_pkg::cmd_t cmd;
	logic busy;
	logic res_valid;
	ntwa_pkg::result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [31:0] cfg_data;

	table_scoreboard sb;
	int unsigned cycles;
	bit no_idle;
	logic [31:0] clock_now;
	logic [31:0] id_pool[8];
	logic [31:0] lane_c;
	logic [7:0] dir_c;

	neighbor_table_with_aging dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.res_valid(res_valid), .result(result), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (res_valid && arst_n) sb.check_result(result);
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout");
			$display("Some tests failed");
			$finish;
		end
	end

	// start stays high after a transaction until the next send or drain decides
	task automatic send(ntwa_pkg::cmd_t c);
		int gap;
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_command(c);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (2 * ntwa_pkg::MAXOUT * (ntwa_pkg::CAPACITY + 4)) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic ntwa_pkg::cmd_t rand_cmd(logic [2:0] k, logic [31:0] id);
		ntwa_pkg::cmd_t c;
		c.kind = k;
		c.sender_id = id;
		c.sender_lane = $urandom;
		c.sender_road = $urandom;
		c.sender_pos_x = $urandom;
		c.sender_pos_y = $urandom;
		c.sender_speed = $urandom;
		c.sender_direction = 8'($urandom);
		c.my_lane = $urandom;
		c.my_direction = 8'($urandom);
		c.now_time = $urandom;
		return c;
	endfunction

	function automatic ntwa_pkg::cmd_t good_hello(logic [31:0] id, logic [31:0] t);
		ntwa_pkg::cmd_t c;
		c = rand_cmd(ntwa_pkg::K_HELLO, id);
		c.sender_lane = lane_c;
		c.my_lane = lane_c;
		c.sender_direction = dir_c;
		c.my_direction = dir_c;
		c.now_time = t;
		return c;
	endfunction

	task automatic random_phase(int n);
		ntwa_pkg::cmd_t c;
		int pick;
		for (int i = 0; i < n; i++) begin
			clock_now += $urandom_range(0, 400);
			pick = $urandom_range(0, 99);
			if (pick < 45) c = good_hello(id_pool[$urandom_range(0, 7)] + $urandom_range(0, 2),
				clock_now - $urandom_range(0, 4000));
			else if (pick < 55)
				c = rand_cmd(ntwa_pkg::K_HELLO, $urandom_range(0, 3) == 0 ? sb.own_id : $urandom);
			else if (pick < 65) begin
				c = rand_cmd(ntwa_pkg::K_PURGE, $urandom);
				c.now_time = clock_now;
			end
			else if (pick < 75)
				c = rand_cmd(ntwa_pkg::K_LOOKUP, id_pool[$urandom_range(0, 7)] + $urandom_range(0, 2));
			else if (pick < 83)
				c = rand_cmd(ntwa_pkg::K_REMOVE, id_pool[$urandom_range(0, 7)] + $urandom_range(0, 2));
			else if (pick < 86) c = rand_cmd(ntwa_pkg::K_CLEAR, $urandom);
			else if (pick < 97) c = rand_cmd(ntwa_pkg::K_LIST, $urandom);
			else c = rand_cmd(3'($urandom_range(6, 7)), $urandom);
			send(c);
		end
	endtask

	initial begin
		ntwa_pkg::cmd_t c;
		sb = new();
		sb.reset_state();
		cycles = 0;
		no_idle = 0;
		clock_now = 5000;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = ntwa_pkg::REG_OWN_ID;
		cfg_data = '0;
		lane_c = 32'hFFFF_FFFF;
		dir_c = 8'hFF;
		foreach (id_pool[i]) id_pool[i] = $urandom;
		id_pool[0] = 32'h0;
		id_pool[1] = 32'hFFFF_FFFD;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every kind, self, mismatch, full table, empty list, absent id
		write_cfg(ntwa_pkg::REG_OWN_ID, 32'h1234_5678);
		send(rand_cmd(ntwa_pkg::K_LIST, 0));
		send(rand_cmd(ntwa_pkg::K_LOOKUP, 32'hFFFF_FFFF));
		send(rand_cmd(ntwa_pkg::K_REMOVE, 0));
		c = good_hello(32'h1234_5678, 0);
		send(c);
		c = good_hello(7, 0);
		c.my_direction = 8'h00;
		send(c);
		c = good_hello(7, 0);
		c.my_lane = 0;
		send(c);
		for (int i = 0; i < ntwa_pkg::CAPACITY; i++)
			send(good_hello(i == 0 ? 32'hFFFF_FFFF : 32'd100 - i, i == 1 ? 32'hFFFF_FFFF : i));
		send(good_hello(32'd500, 0));
		send(good_hello(32'd99, 32'd3));
		send(rand_cmd(ntwa_pkg::K_LOOKUP, 32'hFFFF_FFFF));
		send(rand_cmd(ntwa_pkg::K_LIST, 0));
		c = rand_cmd(ntwa_pkg::K_PURGE, 0);
		c.now_time = 32'd3002;
		send(c);
		send(rand_cmd(3'd6, 0));
		send(rand_cmd(3'd7, 0));
		send(rand_cmd(ntwa_pkg::K_CLEAR, 0));
		drain();

		write_cfg(ntwa_pkg::REG_TIMEOUT, 32'd0);
		write_cfg(ntwa_pkg::REG_OWN_ID, 32'h0);
		lane_c = 0;
		dir_c = 0;
		random_phase(80);
		drain();

		write_cfg(ntwa_pkg::REG_TIMEOUT, 32'hFFFF_FFFF);
		write_cfg(ntwa_pkg::REG_OWN_ID, 32'hFFFF_FFFF);
		lane_c = $urandom;
		dir_c = 8'($urandom);
		random_phase(80);
		drain();

		write_cfg(ntwa_pkg::REG_TIMEOUT, 32'd2500);
		write_cfg(ntwa_pkg::REG_OWN_ID, id_pool[2]);
		random_phase(90);
		no_idle = 1;
		random_phase(60);
		drain();

		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
sv/ntwa_pkg.sv
sv/ntwa_front.sv
sv/ntwa_back.sv
sv/neighbor_table_with_aging.sv
tb/neighbor_table_with_aging_tb.sv
